// File: src/step_sequencer_sine_voice_core_macros.svh
// ----------------------------------------------------------------------------
// step sequencer sine voice assertion macros
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef STEP_SEQUENCER_SINE_VOICE_CORE_MACROS_SVH
`define STEP_SEQUENCER_SINE_VOICE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every rising clock edge outside reset
`define SSV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define SSV_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SSV_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSV_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// File: src/ssv_pkg.sv
// ----------------------------------------------------------------------------
// ssv_pkg
// shared types, tables and constants of the step sequencer sine voice
// ----------------------------------------------------------------------------
package ssv_pkg;

	localparam int STEP_COUNT_DEF = 16;
	localparam int SINE_DEPTH_DEF = 1024;

	// shared divider widths
	localparam int DIV_NW = 48;
	localparam int DIV_DW = 25;

	localparam int ADDR_W = 5;

	typedef struct packed {
		logic [31:0] sample_position;
		logic        playing;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_NW-1:0] quo;
		logic [DIV_DW-1:0] rem;
	} div_rsp_t;

	typedef enum logic [2:0] {
		REG_VOLUME      = 3'd0,
		REG_PAN         = 3'd1,
		REG_MUTE        = 3'd2,
		REG_ROOT_NOTE   = 3'd3,
		REG_VOICE_GAIN  = 3'd4,
		REG_STEP_MASK   = 3'd5,
		REG_SAMPLE_RATE = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POS_ST,
		ST_POS_WT,
		ST_STP_ST,
		ST_STP_WT,
		ST_INC_ST,
		ST_INC_WT,
		ST_ENV_ST,
		ST_ENV_WT,
		ST_MUL_ISS,
		ST_MUL_USE,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_T2,
		OP_H3,
		OP_H2,
		OP_H1,
		OP_H0,
		OP_TR,
		OP_VG,
		OP_ENV,
		OP_GL,
		OP_GR,
		OP_OL,
		OP_OR
	} mul_op_t;

	// q30 taylor coefficients of sin(pi/2 * t)
	localparam logic [31:0] SINC0 = 32'd1686629713;
	localparam logic [31:0] SINC1 = 32'd693598668;
	localparam logic [31:0] SINC2 = 32'd85569306;
	localparam logic [31:0] SINC3 = 32'd5026996;
	localparam logic [31:0] SINC4 = 32'd172272;

	// q4.16 hertz of notes 0..11
	function automatic logic [19:0] freq0(input logic [3:0] semi);
		logic [19:0] f;
		case (semi)
			4'd0:    f = 20'd535809;
			4'd1:    f = 20'd567670;
			4'd2:    f = 20'd601425;
			4'd3:    f = 20'd637188;
			4'd4:    f = 20'd675077;
			4'd5:    f = 20'd715219;
			4'd6:    f = 20'd757749;
			4'd7:    f = 20'd802807;
			4'd8:    f = 20'd850544;
			4'd9:    f = 20'd901120;
			4'd10:   f = 20'd954703;
			default: f = 20'd1011473;
		endcase
		return f;
	endfunction

	function automatic logic [3:0] melody(input logic [2:0] idx);
		logic [3:0] m;
		case (idx)
			3'd0:    m = 4'd0;
			3'd1:    m = 4'd2;
			3'd2:    m = 4'd4;
			3'd3:    m = 4'd7;
			3'd4:    m = 4'd9;
			3'd5:    m = 4'd7;
			3'd6:    m = 4'd4;
			default: m = 4'd2;
		endcase
		return m;
	endfunction

endpackage

// File: src/ssv_div.sv
// ----------------------------------------------------------------------------
// ssv_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssv_div (
	input  logic             clk,
	input  logic             arst_n,
	input  ssv_pkg::div_req_t req,
	output ssv_pkg::div_rsp_t rsp
);
	import ssv_pkg::*;

	localparam int CW = $clog2(DIV_NW + 1);

	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              ge;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = !diff[DIV_DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= CW'(DIV_NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			num_q <= {num_q[DIV_NW-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = num_q;
	assign rsp.rem  = rem_q;

endmodule

// File: src/step_sequencer_sine_voice_core.sv
// ----------------------------------------------------------------------------
// step_sequencer_sine_voice_core
// sixteenth-note step sequencer driving a panned, decaying sine voice
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// in       | in_valid/in_ready   | in_item (sample_position, playing)
// out      | out_valid/out_ready | out_item (left_sample, right_sample)
// cfg      | apb psel/penable    | paddr/pwdata/prdata, 7 registers
//
// a sounding item makes four passes of the shared divider (position wrapped
// to the step pattern, step and in-step offset, phase increment, decay) and
// twelve passes of the shared 32x32 multiplier, each issued and then used; a
// stopped, muted or zero-rate item goes straight to the output, and a disabled
// or late step stops after the first two divider passes
// in_ready is high only in idle; one item is in flight at a time
// a finished item waits in the output register, the core returns to idle and
// takes the next item, holding its result until the register is free
// reset clears the configuration to defaults and the phase to zero
// SINE_TABLE_DEPTH must be a power of two
// ----------------------------------------------------------------------------
`include "step_sequencer_sine_voice_core_macros.svh"

module step_sequencer_sine_voice_core #(
	parameter int STEP_COUNT       = ssv_pkg::STEP_COUNT_DEF,
	parameter int SINE_TABLE_DEPTH = ssv_pkg::SINE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  ssv_pkg::in_item_t          in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ssv_pkg::out_item_t         out_item,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ssv_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import ssv_pkg::*;

	localparam int SW = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
	localparam int AW = $clog2(SINE_TABLE_DEPTH);
	localparam logic [31:0] PH_MASK = ~((32'd1 << (32 - AW)) - 32'd1);

	// configuration registers
	logic [14:0] volume_q;
	logic [15:0] pan_q;
	logic        mute_q;
	logic [6:0]  root_note_q;
	logic [14:0] voice_gain_q;
	logic [15:0] step_mask_q;
	logic [17:0] sample_rate_q;

	logic        cfg_wr;
	cfg_reg_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = cfg_reg_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q      <= 15'd13107;
			pan_q         <= 16'd0;
			mute_q        <= 1'b0;
			root_note_q   <= 7'd60;
			voice_gain_q  <= 15'd3277;
			step_mask_q   <= 16'd9513;
			sample_rate_q <= 18'd48000;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_VOLUME:      volume_q      <= pwdata[14:0];
				REG_PAN:         pan_q         <= pwdata[15:0];
				REG_MUTE:        mute_q        <= pwdata[0];
				REG_ROOT_NOTE:   root_note_q   <= pwdata[6:0];
				REG_VOICE_GAIN:  voice_gain_q  <= pwdata[14:0];
				REG_STEP_MASK:   step_mask_q   <= pwdata[15:0];
				REG_SAMPLE_RATE: sample_rate_q <= pwdata[17:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_VOLUME:      prdata = 32'(volume_q);
			REG_PAN:         prdata = 32'(pan_q);
			REG_MUTE:        prdata = 32'(mute_q);
			REG_ROOT_NOTE:   prdata = 32'(root_note_q);
			REG_VOICE_GAIN:  prdata = 32'(voice_gain_q);
			REG_STEP_MASK:   prdata = 32'(step_mask_q);
			REG_SAMPLE_RATE: prdata = 32'(sample_rate_q);
			default:         prdata = 32'd0;
		endcase
	end

	// sequencer and datapath registers
	state_t      state_q, state_d;
	mul_op_t     op_q;
	logic [31:0] pos_q;
	logic [24:0] wrap_q;
	logic [17:0] rem_q;
	logic [SW-1:0] step_q;
	logic [31:0] inc_q;
	logic [14:0] env_q;
	logic [31:0] phase_q;
	logic [31:0] t2_q;
	logic [31:0] acc_q;
	logic [31:0] gl_q;
	logic [31:0] gr_q;
	logic [15:0] left_q;
	logic [15:0] right_q;
	logic [63:0] mul_q;
	logic        sound_q;
	logic        out_valid_q;
	out_item_t   out_q;

	div_req_t    div_req;
	div_rsp_t    div_rsp;
	logic [31:0] mul_a, mul_b;

	ssv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// first pass wraps 8*position to one pattern of steps, so the second
	// pass gives the step as quotient and the in-step offset as remainder
	logic [SW-1:0] stepv;
	logic [17:0]   remv;
	logic [24:0]   rem100, sr78, srn;
	logic          late, step_on;

	assign stepv   = div_rsp.quo[SW-1:0];
	assign remv    = div_rsp.rem[17:0];
	assign rem100  = 25'(rem_q) * 25'd100;
	assign sr78    = 25'(sample_rate_q) * 25'd78;
	assign srn     = 25'(sample_rate_q) * 25'(STEP_COUNT);
	assign late    = (25'(remv) * 25'd100) > sr78;
	assign step_on = (32'(stepv) < 32'd16) && step_mask_q[4'(stepv)] && !late;

	// note and frequency: octave by reciprocal 171/2048, exact below 144
	logic [7:0]  note;
	logic [3:0]  octave;
	logic [3:0]  semi;
	logic [31:0] freq;
	logic [15:0] note_x;

	assign note   = 8'(root_note_q) + 8'(melody(3'(step_q)));
	assign note_x = 16'(note) * 16'd171;
	assign octave = note_x[14:11];
	assign semi   = 4'(note - 8'(octave) * 8'd12);
	assign freq   = 32'(freq0(semi)) << octave;

	// pan gains inputs
	logic signed [16:0] pan_s, pan_c;
	logic [14:0]        lp, rp;

	assign pan_s = 17'(signed'(pan_q));
	always_comb begin
		if (pan_s > 17'sd16384)
			pan_c = 17'sd16384;
		else if (pan_s < -17'sd16384)
			pan_c = -17'sd16384;
		else
			pan_c = pan_s;
	end
	assign lp = 15'(17'sd16384 - (pan_c > 17'sd0 ? pan_c : 17'sd0));
	assign rp = 15'(17'sd16384 + (pan_c < 17'sd0 ? pan_c : 17'sd0));

	// quarter-wave argument from the quantized phase
	logic [31:0] ph_a;
	logic [31:0] t_arg;
	logic        neg;

	assign ph_a  = phase_q & PH_MASK;
	assign t_arg = ph_a[30] ? (32'h4000_0000 - {2'b00, ph_a[29:0]}) : {2'b00, ph_a[29:0]};
	assign neg   = ph_a[31];

	logic [63:0] rnd14;
	logic [31:0] hi30;
	logic [31:0] sine_r;

	assign rnd14  = (mul_q + 64'd8192) >> 14;
	assign hi30   = mul_q[61:30];
	assign sine_r = (hi30 + 32'd16384) >> 15;

	function automatic logic [15:0] sat16(input logic [63:0] mag, input logic ng);
		logic [16:0] m;
		if (ng) begin
			m = (mag > 64'd32768) ? 17'd32768 : 17'(mag);
			return 16'(17'h10000 - m);
		end
		m = (mag > 64'd32767) ? 17'd32767 : 17'(mag);
		return 16'(m);
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!in_item.playing || mute_q || sample_rate_q == 18'd0)
						state_d = ST_OUT;
					else
						state_d = ST_POS_ST;
				end
			end
			ST_POS_ST: state_d = ST_POS_WT;
			ST_POS_WT: if (div_rsp.done) state_d = ST_STP_ST;
			ST_STP_ST: state_d = ST_STP_WT;
			ST_STP_WT: begin
				if (div_rsp.done)
					state_d = step_on ? ST_INC_ST : ST_OUT;
			end
			ST_INC_ST: state_d = ST_INC_WT;
			ST_INC_WT: if (div_rsp.done) state_d = ST_ENV_ST;
			ST_ENV_ST: state_d = ST_ENV_WT;
			ST_ENV_WT: if (div_rsp.done) state_d = ST_MUL_ISS;
			ST_MUL_ISS: state_d = ST_MUL_USE;
			ST_MUL_USE: state_d = (op_q == OP_OR) ? ST_OUT : ST_MUL_ISS;
			ST_OUT: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs: handshake, divider request, multiplier operands
	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		div_req     = '0;
		mul_a       = 32'd0;
		mul_b       = 32'd0;
		unique case (state_q)
			ST_POS_ST: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NW'({pos_q, 3'b000});
				div_req.den   = srn;
			end
			ST_STP_ST: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NW'(wrap_q);
				div_req.den   = DIV_DW'(sample_rate_q);
			end
			ST_INC_ST: begin
				div_req.start = 1'b1;
				div_req.num   = {freq, 16'd0};
				div_req.den   = DIV_DW'(sample_rate_q);
			end
			ST_ENV_ST: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NW'({sr78 - rem100, 14'd0});
				div_req.den   = sr78;
			end
			default: ;
		endcase
		case (op_q)
			OP_T2: begin
				mul_a = t_arg;
				mul_b = t_arg;
			end
			OP_H3: begin
				mul_a = t2_q;
				mul_b = SINC4;
			end
			OP_H2, OP_H1, OP_H0: begin
				mul_a = t2_q;
				mul_b = acc_q;
			end
			OP_TR: begin
				mul_a = t_arg;
				mul_b = acc_q;
			end
			OP_VG: begin
				mul_a = acc_q;
				mul_b = 32'(voice_gain_q);
			end
			OP_ENV: begin
				mul_a = acc_q;
				mul_b = 32'(env_q);
			end
			OP_GL: begin
				mul_a = 32'(volume_q);
				mul_b = 32'(lp);
			end
			OP_GR: begin
				mul_a = 32'(volume_q);
				mul_b = 32'(rp);
			end
			OP_OL: begin
				mul_a = acc_q;
				mul_b = gl_q;
			end
			OP_OR: begin
				mul_a = acc_q;
				mul_b = gr_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_T2;
			sound_q     <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= 32'd0;
		end else begin
			state_q <= state_d;
			// output register loads a new item or empties on a take
			if (state_q == ST_OUT && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:    if (in_valid) sound_q <= 1'b0;
				ST_INC_ST:  sound_q <= 1'b1;
				ST_ENV_WT:  op_q <= OP_T2;
				ST_MUL_USE: if (op_q != OP_OR) op_q <= mul_op_t'(op_q + 4'd1);
				ST_OUT: begin
					// phase advances only on a sounding item
					if ((!out_valid_q || out_ready) && sound_q)
						phase_q <= phase_q + inc_q;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_valid) pos_q <= in_item.sample_position;
			ST_POS_WT:  if (div_rsp.done) wrap_q <= div_rsp.rem;
			ST_STP_WT: begin
				if (div_rsp.done) begin
					step_q <= stepv;
					rem_q  <= remv;
				end
			end
			ST_INC_WT:  if (div_rsp.done) inc_q <= div_rsp.quo[31:0];
			ST_ENV_WT:  if (div_rsp.done) env_q <= div_rsp.quo[14:0];
			ST_MUL_ISS: mul_q <= 64'(mul_a) * 64'(mul_b);
			ST_MUL_USE: begin
				case (op_q)
					OP_T2:   t2_q  <= hi30;
					OP_H3:   acc_q <= SINC3 - hi30;
					OP_H2:   acc_q <= SINC2 - hi30;
					OP_H1:   acc_q <= SINC1 - hi30;
					OP_H0:   acc_q <= SINC0 - hi30;
					OP_TR:   acc_q <= (sine_r > 32'd32767) ? 32'd32767 : sine_r;
					OP_VG, OP_ENV: acc_q <= rnd14[31:0];
					OP_GL:   gl_q  <= rnd14[31:0];
					OP_GR:   gr_q  <= rnd14[31:0];
					OP_OL:   left_q  <= sat16(rnd14, neg);
					OP_OR:   right_q <= sat16(rnd14, neg);
					default: ;
				endcase
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q.left_sample  <= sound_q ? left_q : 16'd0;
					out_q.right_sample <= sound_q ? right_q : 16'd0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// phase holds outside the output state; it moves only when a sounding item is handed to the output register
	`SSV_ASSERT(a_phase_hold, clk, arst_n, (state_q != ST_OUT) |=> $stable(phase_q), "phase moved outside output load")
	// an accepted item takes the core out of idle
	`SSV_ASSERT(a_accept_busy, clk, arst_n, (in_valid && in_ready) |=> !in_ready, "core still idle after accept")
	// the divider is never restarted while it runs
	`SSV_NEVER(a_div_overlap, clk, arst_n, div_req.start && div_rsp.busy, "divider restarted while busy")

endmodule
